FILE: sv/ddo_pkg.sv
package ddo_pkg;

  localparam int CountWidth  = 16;
  localparam int SineEntries = 1024;
  localparam int RateLimitW  = 44;
  localparam int MicrosPerSec = 1000000;

  typedef enum logic {
    CFG_LINEAR_GAIN  = 1'b0,
    CFG_ANGULAR_GAIN = 1'b1
  } cfg_idx_t;

  // Polynomial quarter-wave sine, evaluated at elaboration for ROM contents.
  function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned entries);
    longint unsigned num, t, rem, t2, r, s, v;
    num = longint'(idx) << 16;
    t   = 0;
    rem = 0;
    // long division of idx*65536 by the table size, one bit per step
    for (int b = 31; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      t   = t << 1;
      if (rem >= longint'(entries)) begin
        rem = rem - longint'(entries);
        t   = t | 64'd1;
      end
    end
    t2 = (t * t) >> 16;
    r  = 42047 - ((t2 * 4640) >> 16);
    r  = 102944 - ((t2 * r) >> 16);
    s  = (t * r) >> 16;
    v  = (s * 32767 + 32768) >> 16;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

endpackage

FILE: sv/ddo_sine.sv
module ddo_sine import ddo_pkg::*; #(
  parameter int SINE_ENTRIES = SineEntries
) (
  input  logic [15:0]        angle,
  output logic signed [15:0] value
);
  localparam int IdxW = $clog2(SINE_ENTRIES);

  logic [15:0] rom [SINE_ENTRIES];
  always_comb begin
    for (int i = 0; i < SINE_ENTRIES; i++) rom[i] = sine_entry(i, SINE_ENTRIES);
  end

  logic [IdxW+14:0] kw;
  logic [IdxW:0]    k, m;
  logic [15:0]      mag;

  always_comb begin
    kw = {{IdxW{1'b0}}, angle[13:0], 1'b0} * (IdxW+15)'(SINE_ENTRIES);
    k  = {1'b0, kw[IdxW+14:15]};
    if (k >= (IdxW+1)'(SINE_ENTRIES)) k = (IdxW+1)'(SINE_ENTRIES - 1);
    m = (IdxW+1)'(SINE_ENTRIES) - k;
    if (angle[14]) begin
      mag = (m >= (IdxW+1)'(SINE_ENTRIES)) ? 16'd32767 : rom[m[IdxW-1:0]];
    end else begin
      mag = rom[k[IdxW-1:0]];
    end
    value = angle[15] ? -$signed(mag) : $signed(mag);
  end
endmodule

FILE: sv/ddo_front.sv
module ddo_front import ddo_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COUNT_WIDTH-1:0] in_left_count,
  input  logic signed [COUNT_WIDTH-1:0] in_right_count,
  input  logic [31:0]                   in_stamp_us,
  output logic                          q_valid,
  input  logic                          q_take,
  output logic signed [COUNT_WIDTH:0]   q_sum,
  output logic signed [COUNT_WIDTH:0]   q_diff,
  output logic [31:0]                   q_stamp,
  output logic [31:0]                   q_dt
);
  // Two-entry queue; dt computed here since prev_stamp depends only on stamps.
  logic [1:0] vld_r, vld_nxt;
  logic       wp_r, rp_r;
  logic signed [COUNT_WIDTH:0] sum_r [2];
  logic signed [COUNT_WIDTH:0] diff_r [2];
  logic [31:0] stamp_r [2];
  logic [31:0] dt_r [2];
  logic [31:0] prev_r;

  assign in_stall = vld_r[wp_r];
  assign q_valid  = vld_r[rp_r];
  assign q_sum    = sum_r[rp_r];
  assign q_diff   = diff_r[rp_r];
  assign q_stamp  = stamp_r[rp_r];
  assign q_dt     = dt_r[rp_r];

  logic push, pop;
  assign push = in_valid && !in_stall;
  assign pop  = q_take && q_valid;

  always_comb begin
    vld_nxt = vld_r;
    if (pop) vld_nxt[rp_r] = 1'b0;
    if (push) vld_nxt[wp_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0; prev_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (pop) rp_r <= ~rp_r;
      if (push) begin
        wp_r <= ~wp_r; prev_r <= in_stamp_us;
      end
    end
    if (push) begin
      sum_r[wp_r]   <= (COUNT_WIDTH+1)'(in_left_count) + (COUNT_WIDTH+1)'(in_right_count);
      diff_r[wp_r]  <= (COUNT_WIDTH+1)'(in_right_count) - (COUNT_WIDTH+1)'(in_left_count);
      stamp_r[wp_r] <= in_stamp_us;
      dt_r[wp_r]    <= in_stamp_us - prev_r;
    end
  end
endmodule

FILE: sv/ddo_back.sv
module ddo_back import ddo_pkg::*; #(
  parameter int COUNT_WIDTH  = CountWidth,
  parameter int SINE_ENTRIES = SineEntries
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [31:0]                 linear_gain,
  input  logic [31:0]                 angular_gain,
  input  logic                        q_valid,
  output logic                        q_take,
  input  logic signed [COUNT_WIDTH:0] q_sum,
  input  logic signed [COUNT_WIDTH:0] q_diff,
  input  logic [31:0]                 q_stamp,
  input  logic [31:0]                 q_dt,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_pos_x,
  output logic signed [31:0]          out_pos_y,
  output logic [15:0]                 out_heading,
  output logic signed [15:0]          out_quat_z,
  output logic signed [15:0]          out_quat_w,
  output logic signed [31:0]          out_lin_velocity,
  output logic signed [31:0]          out_ang_velocity,
  output logic [31:0]                 out_out_stamp,
  output logic                        out_dt_zero
);
  localparam int PW = COUNT_WIDTH + 34;  // signed product width
  localparam int NW = RateLimitW + 20;   // numerator m*1e6 fits here
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_TRIG, S_POSE, S_QUAT, S_LNUM, S_LDIV, S_ANUM, S_ADIV, S_OUT
  } state_t;

  state_t state_r;
  logic signed [PW-1:0] d_r, p_r;
  logic signed [15:0] sa_r, ca_r;
  logic [31:0] x_r, y_r, stamp_r, dt_r;
  logic [15:0] h_r;
  logic signed [15:0] qz_r, qw_r;
  logic signed [31:0] lin_r, ang_r;
  logic zero_r;
  logic [NW-1:0] num_r, quo_r;
  logic [32:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic neg_r;
  logic signed [PW+16:0] mx_r, my_r;

  logic [15:0] ang_a, ang_b;
  logic signed [15:0] sin_a, sin_b;
  ddo_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sa (.angle(ang_a), .value(sin_a));
  ddo_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sb (.angle(ang_b), .value(sin_b));

  always_comb begin
    if (state_r == S_QUAT) begin
      ang_a = {1'b0, h_r[15:1]};
      ang_b = {1'b0, h_r[15:1]} + 16'd16384;
    end else begin
      ang_a = h_r;
      ang_b = h_r + 16'd16384;
    end
  end

  // magnitude of the selected rate source, clamped to 2^44
  logic signed [PW-1:0] src;
  logic [PW-1:0] mag;
  logic [RateLimitW:0] magc;
  assign src  = (state_r == S_LNUM) ? d_r : p_r;
  assign mag  = src[PW-1] ? PW'(-src) : PW'(src);
  assign magc = (mag > PW'(64'h1 << RateLimitW)) ? (RateLimitW+1)'(64'h1 << RateLimitW)
                                                 : mag[RateLimitW:0];

  logic [32:0] rsh;
  assign rsh = {rem_r[31:0], num_r[NW-1]};

  function automatic logic signed [31:0] sat(input logic [NW-1:0] q, input logic n);
    if (n) return (q >= NW'(64'h80000000)) ? 32'sh80000000 : -$signed(q[31:0]);
    return (q > NW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
  endfunction

  logic signed [PW+16:0] dxw, dyw;
  logic signed [PW:0] pr;
  assign dxw = mx_r + (PW+17)'(16384);
  assign dyw = my_r + (PW+17)'(16384);
  assign pr  = (PW+1)'(p_r) + (PW+1)'(32768);

  assign q_take    = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_pos_x = x_r;
  assign out_pos_y = y_r;
  assign out_heading = h_r;
  assign out_quat_z = qz_r;
  assign out_quat_w = qw_r;
  assign out_lin_velocity = lin_r;
  assign out_ang_velocity = ang_r;
  assign out_out_stamp = stamp_r;
  assign out_dt_zero = zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; x_r <= '0; y_r <= '0; h_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          d_r <= ($signed(PW'(q_sum) * $signed({1'b0, linear_gain})) + PW'(32768)) >>> 16;
          p_r <= PW'(q_diff) * $signed({1'b0, angular_gain});
          stamp_r <= q_stamp; dt_r <= q_dt; zero_r <= (q_dt == 32'd0);
          state_r <= S_PROD;
        end
        S_PROD: begin
          sa_r <= sin_a; ca_r <= sin_b; state_r <= S_TRIG;
        end
        S_TRIG: begin
          mx_r <= (PW+17)'(d_r) * (PW+17)'(ca_r);
          my_r <= (PW+17)'(d_r) * (PW+17)'(sa_r);
          state_r <= S_POSE;
        end
        S_POSE: begin
          x_r <= x_r + 32'(dxw >>> 15);
          y_r <= y_r + 32'(dyw >>> 15);
          h_r <= h_r + 16'(pr >>> 16);
          state_r <= S_QUAT;
        end
        S_QUAT: begin
          qz_r <= sin_a; qw_r <= sin_b;
          lin_r <= '0; ang_r <= '0;
          state_r <= zero_r ? S_OUT : S_LNUM;
        end
        S_LNUM, S_ANUM: begin
          num_r <= NW'(magc) * NW'(MicrosPerSec);
          neg_r <= src[PW-1];
          rem_r <= '0; quo_r <= '0; cnt_r <= CW'(NW);
          state_r <= (state_r == S_LNUM) ? S_LDIV : S_ADIV;
        end
        S_LDIV, S_ADIV: begin
          if (cnt_r == '0) begin
            if (state_r == S_LDIV) begin
              lin_r <= sat(quo_r, neg_r); state_r <= S_ANUM;
            end else begin
              ang_r <= sat(quo_r, neg_r); state_r <= S_OUT;
            end
          end else begin
            num_r <= num_r << 1;
            cnt_r <= cnt_r - 1'b1;
            if (rsh >= {1'b0, dt_r}) begin
              rem_r <= rsh - {1'b0, dt_r}; quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rsh; quo_r <= {quo_r[NW-2:0], 1'b0};
            end
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/diff_drive_odometry.sv
// The back end steps through product, trig, pose and quaternion states, then, when
// dt is nonzero, two 64-step restoring divisions before it offers the result.
// It takes no new item until the result is taken, so the shared serial divider
// and output stalls set the pace.
// A two-item queue lets the input side take items while the back end works.
// Reset (rst_n low, synchronous) clears pose, heading, last stamp and gains.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int COUNT_WIDTH  = CountWidth,
  parameter int SINE_ENTRIES = SineEntries
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COUNT_WIDTH-1:0] in_left_count,
  input  logic signed [COUNT_WIDTH-1:0] in_right_count,
  input  logic [31:0]                   in_stamp_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic [15:0]                   out_heading,
  output logic signed [15:0]            out_quat_z,
  output logic signed [15:0]            out_quat_w,
  output logic signed [31:0]            out_lin_velocity,
  output logic signed [31:0]            out_ang_velocity,
  output logic [31:0]                   out_out_stamp,
  output logic                          out_dt_zero
);
  logic [31:0] lin_gain_r, ang_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= '0; ang_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINEAR_GAIN:  lin_gain_r <= cfg_data;
        CFG_ANGULAR_GAIN: ang_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_valid, q_take;
  logic signed [COUNT_WIDTH:0] q_sum, q_diff;
  logic [31:0] q_stamp, q_dt;

  ddo_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_left_count, .in_right_count, .in_stamp_us,
    .q_valid, .q_take, .q_sum, .q_diff, .q_stamp, .q_dt
  );

  ddo_back #(.COUNT_WIDTH(COUNT_WIDTH), .SINE_ENTRIES(SINE_ENTRIES)) u_back (
    .clk, .rst_n, .linear_gain(lin_gain_r), .angular_gain(ang_gain_r),
    .q_valid, .q_take, .q_sum, .q_diff, .q_stamp, .q_dt,
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_heading, .out_quat_z,
    .out_quat_w, .out_lin_velocity, .out_ang_velocity, .out_out_stamp, .out_dt_zero
  );
endmodule

FILE: sim/tb_diff_drive_odometry.sv
`timescale 1ns / 1ps

module tb_diff_drive_odometry;
  import ddo_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [31:0]        stamp;
  } odo_in_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic [31:0] lin_vel;
    logic [31:0] ang_vel;
    logic [31:0] stamp;
    logic        dt_zero;
  } odo_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_REST, ROW_LIN, ROW_ANG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] lc;
    logic [15:0] rc;
    logic [31:0] word;
    logic        dtz;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_left_count = '0;
  logic signed [15:0] in_right_count = '0;
  logic [31:0] in_stamp_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_lin_velocity, out_ang_velocity;
  logic [15:0] out_heading;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic [31:0] out_out_stamp;
  logic out_dt_zero;

  diff_drive_odometry dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] sine_rom [SineEntries];
  logic [31:0] lin_gain, ang_gain;
  logic [31:0] pose_x, pose_y, prev_stamp;
  logic [15:0] pose_heading;

  odo_res_t expected_poses[$];
  int errors = 0;
  bit calm = 1'b0;

  function automatic int sin_of(logic [15:0] a);
    int k, m, v;
    k = (int'(a[13:0]) * SineEntries) >> 14;
    if (k >= SineEntries) k = SineEntries - 1;
    if (a[14]) begin
      m = SineEntries - k;
      v = (m >= SineEntries) ? 32767 : int'(sine_rom[m]);
    end else begin
      v = int'(sine_rom[k]);
    end
    return a[15] ? -v : v;
  endfunction

  function automatic logic [31:0] rate_of(longint v, logic [31:0] dt);
    longint unsigned m, q;
    bit neg;
    neg = v < 0;
    m = neg ? -v : v;
    if (m > (64'd1 << 44)) m = 64'd1 << 44;
    q = m * 64'd1000000 / {32'b0, dt};
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic odo_res_t pose_update(odo_in_t it);
    longint l, r, d, p, dx, dy, turn;
    logic [31:0] dt;
    logic [15:0] old_h, half;
    odo_res_t res;
    l = it.left;
    r = it.right;
    dt = it.stamp - prev_stamp;
    old_h = pose_heading;
    d = ((l + r) * longint'({32'b0, lin_gain}) + 32768) >>> 16;
    p = (r - l) * longint'({32'b0, ang_gain});
    dx = (d * sin_of(old_h + 16'd16384) + 16384) >>> 15;
    dy = (d * sin_of(old_h) + 16384) >>> 15;
    turn = (p + 32768) >>> 16;
    pose_x = pose_x + dx[31:0];
    pose_y = pose_y + dy[31:0];
    pose_heading = old_h + turn[15:0];
    prev_stamp = it.stamp;
    half = pose_heading >> 1;
    res.pos_x = pose_x;
    res.pos_y = pose_y;
    res.heading = pose_heading;
    res.quat_z = 16'(sin_of(half));
    res.quat_w = 16'(sin_of(half + 16'd16384));
    res.lin_vel = (dt == 0) ? '0 : rate_of(d, dt);
    res.ang_vel = (dt == 0) ? '0 : rate_of(p, dt);
    res.stamp = it.stamp;
    res.dt_zero = (dt == 0);
    return res;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_LINEAR_GAIN) lin_gain = value;
    else ang_gain = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, let the pipeline drain, then allow register writes
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_item(odo_in_t it, odo_res_t typed, bit use_typed);
    int gap;
    bit take;
    odo_res_t pred;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_left_count <= it.left;
    in_right_count <= it.right;
    in_stamp_us <= it.stamp;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      take = !in_stall;
      @(posedge clk);
    end while (!take);
    pred = pose_update(it);
    expected_poses.push_back(use_typed ? typed : pred);
  endtask

  task automatic note_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10)
        $display("%0t %s mismatch: expected %h, got %h", $realtime, name, e, a);
    end
  endtask

  // result side: check at the falling edge, where outputs are settled
  int hold_cnt = 0;
  bit res_take = 1'b0;
  bit in_take = 1'b0;
  int idle_cycles = 0;

  always @(negedge clk) begin
    odo_res_t e;
    res_take = out_valid && !out_stall && rst_n;
    in_take = in_valid && !in_stall && rst_n;
    if (res_take) begin
      if (expected_poses.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t result with nothing expected", $realtime);
      end else begin
        e = expected_poses.pop_front();
        note_field("pos_x", e.pos_x, out_pos_x);
        note_field("pos_y", e.pos_y, out_pos_y);
        note_field("heading", e.heading, out_heading);
        note_field("quat_z", e.quat_z, {16'h0000, out_quat_z});
        note_field("quat_w", e.quat_w, {16'h0000, out_quat_w});
        note_field("lin_velocity", e.lin_vel, out_lin_velocity);
        note_field("ang_velocity", e.ang_vel, out_ang_velocity);
        note_field("out_stamp", e.stamp, out_out_stamp);
        note_field("dt_zero", e.dt_zero, out_dt_zero);
      end
    end
    if (res_take || in_take) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_diff_drive_odometry: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt = 0;
    end else if (res_take) begin
      hold_cnt = calm ? 0 : $urandom_range(0, 15);
    end else if (out_valid && hold_cnt > 0) begin
      hold_cnt--;
    end
    out_stall <= (hold_cnt != 0);
  end

  row_t steps[] = '{
    '{ROW_REST, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1},
    '{ROW_REST, 16'h8000, 16'h7FFF, 32'h0000_0005, 1'b0},
    '{ROW_REST, 16'hFFFF, 16'h0001, 32'h0000_0005, 1'b1},
    '{ROW_LIN,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0},
    '{ROW_ANG,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0},
    '{ROW_ITEM, 16'h7FFF, 16'h7FFF, 32'h0000_0006, 1'b0},
    '{ROW_ITEM, 16'h8000, 16'h8000, 32'h0000_0007, 1'b0},
    '{ROW_ITEM, 16'h8000, 16'h7FFF, 32'h0000_0007, 1'b0},
    '{ROW_ITEM, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 1'b0},
    '{ROW_ITEM, 16'h0001, 16'h0000, 32'h0000_0003, 1'b0},
    '{ROW_ITEM, 16'h0000, 16'h0000, 32'h0000_0004, 1'b0},
    '{ROW_LIN,  16'h0000, 16'h0000, 32'h0041_8937, 1'b0},
    '{ROW_ANG,  16'h0000, 16'h0000, 32'h4000_0000, 1'b0},
    '{ROW_ITEM, 16'h0010, 16'h0011, 32'h0000_1000, 1'b0},
    '{ROW_ITEM, 16'h0010, 16'h0011, 32'h0000_2000, 1'b0},
    '{ROW_ITEM, 16'h0010, 16'h0011, 32'h0000_2000, 1'b0},
    '{ROW_ITEM, 16'h0010, 16'h0011, 32'h0000_3000, 1'b0},
    '{ROW_ITEM, 16'h0064, 16'h0064, 32'h0000_4000, 1'b0},
    '{ROW_ITEM, 16'hFF00, 16'h0100, 32'h0000_4001, 1'b0}
  };

  initial begin
    odo_in_t it;
    odo_res_t rest;
    logic [31:0] stamp_now;
    longint unsigned t, t2, c, s, v;
    for (int i = 0; i < SineEntries; i++) begin
      t = (longint'(i) << 16) / SineEntries;
      t2 = (t * t) >> 16;
      c = 42047 - ((t2 * 4640) >> 16);
      c = 102944 - ((t2 * c) >> 16);
      s = (t * c) >> 16;
      v = (s * 32767 + 32768) >> 16;
      sine_rom[i] = (v > 32767) ? 16'd32767 : v[15:0];
    end
    lin_gain = '0;
    ang_gain = '0;
    pose_x = '0;
    pose_y = '0;
    pose_heading = '0;
    prev_stamp = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_LIN: begin
          wait_idle();
          write_reg(CFG_LINEAR_GAIN, steps[i].word);
        end
        ROW_ANG: begin
          wait_idle();
          write_reg(CFG_ANGULAR_GAIN, steps[i].word);
        end
        default: begin
          it = '{steps[i].lc, steps[i].rc, steps[i].word};
          // rest rows come while the gains are zero: the robot stays at the origin facing forward
          rest = '{32'd0, 32'd0, 16'd0, 16'd0, 16'd32767, 32'd0, 32'd0,
                   steps[i].word, steps[i].dtz};
          send_item(it, rest, steps[i].kind == ROW_REST);
        end
      endcase
    end

    stamp_now = 32'h0000_4001;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      calm = (ph % 3 == 2);
      case (ph)
        0: begin
          write_reg(CFG_LINEAR_GAIN, $urandom_range(0, 32'h00FF_FFFF));
          write_reg(CFG_ANGULAR_GAIN, $urandom_range(0, 32'h00FF_FFFF));
        end
        1: begin
          write_reg(CFG_LINEAR_GAIN, 32'h0000_0000);
          write_reg(CFG_ANGULAR_GAIN, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CFG_LINEAR_GAIN, 32'hFFFF_FFFF);
          write_reg(CFG_ANGULAR_GAIN, 32'h0000_0000);
        end
        default: begin
          write_reg(CFG_LINEAR_GAIN, $urandom);
          write_reg(CFG_ANGULAR_GAIN, $urandom);
        end
      endcase
      for (int n = 0; n < 222; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          it = '{$urandom, $urandom, $urandom};
        end else begin
          it.left = $urandom_range(0, 400) - 200;
          it.right = $urandom_range(0, 400) - 200;
          case ($urandom_range(0, 7))
            0: it.stamp = stamp_now;
            1: it.stamp = stamp_now + $urandom;
            default: it.stamp = stamp_now + $urandom_range(1, 100000);
          endcase
        end
        stamp_now = it.stamp;
        send_item(it, '0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("tb_diff_drive_odometry: clean");
    end else begin
      $display("tb_diff_drive_odometry: errors");
    end
    $finish;
  end

endmodule
